@@ hw/rtl/rde_pkg.sv @@
// Shared types and constants for the radix digit encoder.
// Holds the word structs, the controller/datapath link and the register map.
// No dependencies.
package rde_pkg;

    // Input value and its division schedule
    localparam int VALUE_W     = 128;
    localparam int HALF_W      = 64;
    localparam int CHUNK_W     = 16;                   // dividend bits retired per chunk
    localparam int CHUNKS      = VALUE_W / CHUNK_W;
    localparam int STEPS       = 2 * CHUNKS;           // steps per digit: estimate, correct
    localparam int STEP_CNT_W  = $clog2(STEPS);
    localparam logic [STEP_CNT_W-1:0] STEP_LAST = STEP_CNT_W'(STEPS - 1);

    // Result fields
    localparam int DIGIT_W     = 18;
    localparam int POS_W       = 3;
    localparam int LIMIT_W     = 4;
    localparam logic [LIMIT_W-1:0] DIGIT_LIMIT_MAX = 4'd8;
    localparam logic [LIMIT_W-1:0] MAX_DIGITS_RESET = 4'd8;

    // Register map
    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;
    localparam logic [0:0] REG_IDX_MAX_DIGITS = 1'b0;

    typedef struct packed {
        logic [HALF_W-1:0] value_high;
        logic [HALF_W-1:0] value_low;
    } in_word_t;

    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic [POS_W-1:0]   digit_position;
        logic               final_digit;
    } out_word_t;

    typedef struct packed {
        logic load;   // take a new value
        logic step;   // one division step
        logic emit;   // move the finished digit to the output register
    } rde_cmd_t;

    typedef struct packed {
        logic in_zero;
        logic limit_zero;
        logic div_done;
        logic out_free;
        logic last_digit;
    } rde_status_t;

endpackage

@@ hw/rtl/radix_digit_encoder_128.sv @@
// Top level of the radix digit encoder: APB register, controller, datapath.
// Depends on rde_pkg, rde_ctrl and rde_dpath.
//
// Usage:
//   s_ channel (valid/ready) takes one word: a 128-bit unsigned value as two
//   64-bit halves. m_ channel (valid/ready) returns one word per base-RADIX
//   digit, least significant first, with its position and a final marker.
//   The APB register max_digits (address 0, 4 bits, reset 8) caps the
//   digits per value; values above 8 act as 8. Write it only while idle.
// Operation:
//   Each digit takes a division over eight 16-bit chunks, each in an estimate
//   step (a reciprocal multiply estimates the chunk quotient) and a correct
//   step (a multiply-back corrects it by at most one), then an emit step that
//   loads the output register. The next word is taken only once the last
//   digit of a value has been emitted and the block is idle. A zero value or
//   a zero limit is taken and dropped without leaving idle.
// Stalls:
//   The output register holds a digit while m_ready is low; the next digit
//   is computed meanwhile and waits until the register frees up.
// Reset:
//   aresetn (synchronous, active low) returns the sequencer to idle, drops
//   any pending output and sets max_digits back to 8.
module radix_digit_encoder_128 #(
    parameter int RADIX = 150000
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input words
    input  logic                          s_valid,
    output logic                          s_ready,
    input  rde_pkg::in_word_t             s_data,
    // result words
    output logic                          m_valid,
    input  logic                          m_ready,
    output rde_pkg::out_word_t            m_data,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rde_pkg::ADDR_W-1:0]    paddr,
    input  logic [rde_pkg::DATA_W-1:0]    pwdata,
    output logic [rde_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    logic [rde_pkg::LIMIT_W-1:0] max_digits_reg;
    logic [rde_pkg::LIMIT_W-1:0] limit;
    logic                        reg_sel;
    rde_pkg::rde_cmd_t           cmd;
    rde_pkg::rde_status_t        status;

    // Register file: one register, word address taken from paddr[2]
    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == rde_pkg::REG_IDX_MAX_DIGITS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_digits_reg <= rde_pkg::MAX_DIGITS_RESET;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            max_digits_reg <= pwdata[rde_pkg::LIMIT_W-1:0];
        end
    end

    assign prdata = reg_sel ? rde_pkg::DATA_W'(max_digits_reg) : '0;

    // Clamp the limit to the most digits one value can produce
    assign limit = (max_digits_reg > rde_pkg::DIGIT_LIMIT_MAX) ? rde_pkg::DIGIT_LIMIT_MAX
                   : max_digits_reg;

    rde_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    rde_dpath #(
        .RADIX (RADIX)
    ) u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .limit   (limit),
        .cmd     (cmd),
        .status  (status),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

@@ hw/rtl/rde_ctrl.sv @@
// Sequencer for the radix digit encoder.
// Drives load/step/emit commands from datapath status; uses rde_pkg.
module rde_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  rde_pkg::rde_status_t status,
    output rde_pkg::rde_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                // zero value or zero limit: nothing to emit, stay put
                if (s_valid && !status.in_zero && !status.limit_zero) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.step = 1'b1;
                if (status.div_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = status.last_digit ? ST_IDLE : ST_DIV;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/rde_dpath.sv @@
// Datapath for the radix digit encoder: long division by a constant base,
// one 16-bit chunk per estimate/correct step pair by reciprocal multiply, plus the result register.
// Uses rde_pkg.
module rde_dpath #(
    parameter int RADIX = 150000
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  rde_pkg::in_word_t                  s_data,
    input  logic [rde_pkg::LIMIT_W-1:0]        limit,
    input  rde_pkg::rde_cmd_t                  cmd,
    output rde_pkg::rde_status_t               status,
    output logic                               m_valid,
    input  logic                               m_ready,
    output rde_pkg::out_word_t                 m_data
);

    localparam int REM_W   = $clog2(RADIX);
    localparam int PART_W  = REM_W + rde_pkg::CHUNK_W;
    localparam int PROD_W  = PART_W + rde_pkg::CHUNK_W;
    localparam int RECIP_W = rde_pkg::CHUNK_W + 1;
    // floor(2^PART_W / RADIX): the estimate is never above the true quotient
    // and falls short of it by at most one
    localparam logic [63:0]        RECIP_FULL = (64'd1 << PART_W) / 64'(RADIX);
    localparam logic [RECIP_W-1:0] RECIP      = RECIP_FULL[RECIP_W-1:0];
    localparam logic [PART_W-1:0]  RADIX_P    = PART_W'(RADIX);

    logic [rde_pkg::VALUE_W-1:0]     dividend_reg, dividend_next;
    logic [REM_W-1:0]                rem_reg, rem_next;
    logic [rde_pkg::CHUNK_W-1:0]     q_est_reg, q_est_next;
    logic [rde_pkg::STEP_CNT_W-1:0]  step_cnt_reg;
    logic [rde_pkg::POS_W-1:0]       digit_cnt_reg;
    logic                            m_valid_reg;
    rde_pkg::out_word_t              m_data_reg;

    logic                            fix_phase;
    logic [PART_W-1:0]               part;
    logic [PROD_W-1:0]               prod;
    logic [PART_W-1:0]               back;
    logic [PART_W-1:0]               diff;
    logic [rde_pkg::CHUNK_W-1:0]     q_chunk;
    logic                            quo_zero;
    logic                            limit_hit;

    // Partial dividend: running remainder above the top chunk
    assign part      = {rem_reg, dividend_reg[rde_pkg::VALUE_W-1 -: rde_pkg::CHUNK_W]};
    assign fix_phase = step_cnt_reg[0];

    // Estimate cycle: multiply by the reciprocal
    assign prod       = PROD_W'(part) * PROD_W'(RECIP);
    assign q_est_next = prod[PROD_W-1 -: rde_pkg::CHUNK_W];

    // Correct cycle: multiply back, subtract, bump the quotient by one if needed
    assign back = PART_W'(q_est_reg) * RADIX_P;
    assign diff = part - back;

    always_comb begin
        if (diff >= RADIX_P) begin
            q_chunk  = q_est_reg + rde_pkg::CHUNK_W'(1);
            rem_next = REM_W'(diff - RADIX_P);
        end else begin
            q_chunk  = q_est_reg;
            rem_next = diff[REM_W-1:0];
        end
    end

    assign dividend_next = {dividend_reg[rde_pkg::VALUE_W-rde_pkg::CHUNK_W-1:0], q_chunk};

    assign quo_zero  = (dividend_reg == '0);
    assign limit_hit = (({1'b0, digit_cnt_reg} + rde_pkg::LIMIT_W'(1)) == limit);

    assign status.in_zero    = (s_data == '0);
    assign status.limit_zero = (limit == '0);
    assign status.div_done   = (step_cnt_reg == rde_pkg::STEP_LAST);
    assign status.out_free   = !m_valid_reg || m_ready;
    assign status.last_digit = quo_zero || limit_hit;

    // Control counters and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_cnt_reg  <= '0;
            digit_cnt_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cmd.load) begin
                step_cnt_reg  <= '0;
                digit_cnt_reg <= '0;
            end else if (cmd.step) begin
                step_cnt_reg <= (step_cnt_reg == rde_pkg::STEP_LAST) ? '0
                                : step_cnt_reg + 1'b1;
            end else if (cmd.emit) begin
                digit_cnt_reg <= digit_cnt_reg + 1'b1;
            end

            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Dividend, remainder, chunk estimate and result word
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            dividend_reg <= s_data;
            rem_reg      <= '0;
        end else if (cmd.step && !fix_phase) begin
            q_est_reg    <= q_est_next;
        end else if (cmd.step) begin
            dividend_reg <= dividend_next;
            rem_reg      <= rem_next;
        end else if (cmd.emit) begin
            rem_reg <= '0;
        end

        if (cmd.emit) begin
            m_data_reg.digit          <= rde_pkg::DIGIT_W'(rem_reg);
            m_data_reg.digit_position <= digit_cnt_reg;
            m_data_reg.final_digit    <= quo_zero || limit_hit;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ sim/tb_radix_digit_encoder_128.sv @@
`timescale 1ns / 1ps
// Testbench for radix_digit_encoder_128: sends 128-bit values, predicts their base-RADIX
// digit words and checks every word that comes out. Depends on rde_pkg and the encoder RTL.

module tb;
    import rde_pkg::*;

    localparam int RADIX           = 150000;
    localparam int SETTLE_CYCLES   = 40;     // covers one digit time and the drop of a zero value
    localparam int STALL_LIMIT     = 2000;   // cycles with no handshake before giving up
    localparam int PRESSURE_CYCLES = 300;    // long output hold-off that backs up the input
    localparam logic [ADDR_W-1:0] MAX_DIGITS_ADDR = ADDR_W'(4 * REG_IDX_MAX_DIGITS);

    logic              aclk    = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    in_word_t          s_data  = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    out_word_t         m_data;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [DATA_W-1:0] pwdata  = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // Shadow of max_digits and the digit words still owed by the block, oldest first
    logic [LIMIT_W-1:0] digit_cap = MAX_DIGITS_RESET;
    out_word_t          digits_due[$];

    // Shared controls: burst_mode drops all random gaps on both sides,
    // pressure_hold asks the receiver for one long hold-off
    bit burst_mode    = 1'b0;
    int pressure_hold = 0;

    int mismatch_count = 0;
    int values_sent    = 0;
    int digits_checked = 0;
    int reg_writes     = 0;
    int quiet_cycles   = 0;

    radix_digit_encoder_128 #(.RADIX(RADIX)) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 aclk = ~aclk;

    // Divide the whole 128-bit value by RADIX until it runs out or the cap is hit;
    // queue one digit word per remainder, marking the last one.
    function automatic void predict_digits(in_word_t w);
        logic [VALUE_W-1:0] rest;
        logic [VALUE_W-1:0] rem;
        int                 cap;
        int                 n;
        out_word_t          d;
        rest = {w.value_high, w.value_low};
        cap  = (digit_cap > DIGIT_LIMIT_MAX) ? int'(DIGIT_LIMIT_MAX) : int'(digit_cap);
        n    = 0;
        while (rest != '0 && n < cap) begin
            rem              = rest % VALUE_W'(RADIX);
            rest             = rest / VALUE_W'(RADIX);
            d.digit          = rem[DIGIT_W-1:0];
            d.digit_position = n[POS_W-1:0];
            d.final_digit    = (rest == '0) || (n + 1 >= cap);
            digits_due.push_back(d);
            n++;
        end
    endfunction

    function automatic logic [VALUE_W-1:0] radix_power(int k);
        logic [VALUE_W-1:0] p;
        p = 1;
        repeat (k) p = p * VALUE_W'(RADIX);
        return p;
    endfunction

    // Mix of full-width values, short values (spread of digit counts),
    // multiples of RADIX powers (runs of zero digits) and zero.
    function automatic logic [VALUE_W-1:0] random_value();
        logic [VALUE_W-1:0] v;
        int                 kind;
        int                 width;
        v    = {$urandom, $urandom, $urandom, $urandom};
        kind = $urandom_range(0, 15);
        if (kind == 0) begin
            v = '0;
        end else if (kind < 3) begin
            v = radix_power($urandom_range(0, 7)) * VALUE_W'($urandom_range(1, 100));
        end else if (kind < 9) begin
            width = $urandom_range(1, VALUE_W);
            v     = v >> (VALUE_W - width);
        end
        return v;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Offer one word after a random gap; keep valid high afterwards so a
    // zero gap gives back-to-back words.
    task automatic send_value(logic [HALF_W-1:0] high, logic [HALF_W-1:0] low);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= {high, low};
        do @(posedge aclk); while (s_ready !== 1'b1);
        predict_digits(in_word_t'({high, low}));
        values_sent++;
    endtask

    // Drain the block, then write max_digits and read it back over APB.
    task automatic write_max_digits(logic [LIMIT_W-1:0] limit);
        logic [DATA_W-1:0] word;
        s_valid <= 1'b0;
        while (digits_due.size() != 0) @(posedge aclk);
        // a zero value or zero limit owes nothing but may still be in flight
        repeat (SETTLE_CYCLES) @(posedge aclk);
        word = $urandom;
        if ($urandom_range(0, 1)) word = '0;
        word[LIMIT_W-1:0] = limit;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= MAX_DIGITS_ADDR;
        pwdata  <= word;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        digit_cap = limit;
        reg_writes++;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        if (prdata[LIMIT_W-1:0] !== limit)
            report_mismatch("max_digits readback", prdata[LIMIT_W-1:0], limit);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Extremes under the reset limit of eight digits
    task automatic test_default_limit();
        logic [VALUE_W-1:0] p7;
        p7 = radix_power(7);
        send_value('0, '0);                        // zero value: no words
        send_value('0, 64'd1);
        send_value('0, HALF_W'(RADIX - 1));        // largest single digit
        send_value('0, HALF_W'(RADIX));            // digits 0 then 1
        send_value(p7[VALUE_W-1:HALF_W], p7[HALF_W-1:0]);  // seven zeros, then 1
        send_value('1, '1);                        // largest value, eight digits
        send_value('0, '1);
        send_value(64'd1, '0);
        send_value({32{2'b10}}, {32{2'b01}});
        send_value({32{2'b01}}, {32{2'b10}});
    endtask

    // Limit of zero, truncation, and the limits above eight that act as eight
    task automatic test_limit_extremes();
        logic [VALUE_W-1:0] p7;
        logic [VALUE_W-1:0] nines;
        p7    = radix_power(7);
        nines = p7 - 1;                            // seven digits of RADIX-1
        write_max_digits(4'd0);
        send_value('1, '1);
        send_value('0, '0);
        write_max_digits(4'd1);
        send_value('1, '1);
        send_value('0, HALF_W'(RADIX));
        write_max_digits(4'd3);
        send_value('1, '1);
        send_value(nines[VALUE_W-1:HALF_W], nines[HALF_W-1:0]);
        write_max_digits(4'd15);
        send_value('1, '1);
        send_value('0, 64'd1);
        write_max_digits(4'd9);
        send_value(p7[VALUE_W-1:HALF_W], p7[HALF_W-1:0]);
    endtask

    // Hold the output off for a long stretch while words keep coming, so the
    // output register and the divider both fill and s_ready drops.
    task automatic test_output_backpressure();
        logic [VALUE_W-1:0] v;
        write_max_digits(4'd8);
        pressure_hold = PRESSURE_CYCLES;
        burst_mode    = 1'b1;
        repeat (12) begin
            v = random_value();
            send_value(v[VALUE_W-1:HALF_W], v[HALF_W-1:0]);
        end
        burst_mode = 1'b0;
    endtask

    // Random values across several limit settings, with bursts mixed in
    task automatic test_random_traffic();
        logic [LIMIT_W-1:0] phase_limits [8];
        logic [VALUE_W-1:0] v;
        phase_limits = '{4'd8, 4'd5, 4'd15, 4'd2, 4'd8, 4'd7, 4'd1, 4'd4};
        phase_limits[5] = LIMIT_W'($urandom_range(0, 15));
        foreach (phase_limits[p]) begin
            write_max_digits(phase_limits[p]);
            burst_mode = (p == 4);
            repeat (25) begin
                v = random_value();
                send_value(v[VALUE_W-1:HALF_W], v[HALF_W-1:0]);
                if ($urandom_range(0, 19) == 0) burst_mode = !burst_mode;
            end
            burst_mode = 1'b0;
        end
    endtask

    // Receiver: random ready gaps per word, plus the long hold-off on request
    initial begin
        int stall;
        forever begin
            if (pressure_hold > 0) begin
                m_ready <= 1'b0;
                repeat (pressure_hold) @(posedge aclk);
                pressure_hold = 0;
            end
            stall = burst_mode ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
        end
    end

    // Checker: compare each accepted digit word with the oldest prediction
    always @(posedge aclk) begin
        out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (digits_due.size() == 0) begin
                report_mismatch("digit word with nothing owed", m_data.digit, -1);
            end else begin
                want = digits_due.pop_front();
                if (m_data.digit !== want.digit)
                    report_mismatch("digit", m_data.digit, want.digit);
                if (m_data.digit_position !== want.digit_position)
                    report_mismatch("digit_position", m_data.digit_position,
                                    want.digit_position);
                if (m_data.final_digit !== want.final_digit)
                    report_mismatch("final_digit", m_data.final_digit, want.final_digit);
                digits_checked++;
            end
        end
    end

    // Watchdog: count cycles in which no word and no register access moves
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d digit words still owed",
                     STALL_LIMIT, digits_due.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        // hold reset, then release
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_default_limit();
        test_limit_extremes();
        test_output_backpressure();
        test_random_traffic();

        // drop valid, wait out the owed words, then watch for strays
        s_valid <= 1'b0;
        while (digits_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Sent %0d values and checked %0d digit words over %0d max_digits writes,",
                 values_sent, digits_checked, reg_writes);
        $display("covering zero values, limits 0 to 15, truncation and a long output stall.");
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
